>>> rtl/core/lifa_pkg.sv
// shared types and constants for the lazy-init free-list block allocator
// no dependencies

package lifa_pkg;

   localparam int LINK_W      = 11;
   localparam int BLK_W       = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 2;
   localparam int TOTAL_RESET = 1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              we;
      logic [LINK_W-1:0] waddr;
      logic [LINK_W-1:0] wdata;
      logic [LINK_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [BLK_W-1:0]  block_out;
      logic              granted;
      logic              rejected;
      logic [LINK_W-1:0] free_blocks;
   } result_type;

endpackage

>>> rtl/core/lifa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module lifa_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/lifa_ctrl.sv
// free-list control: head, free count, lazy init pointer and pop sequencing
// depends on lifa_pkg

module lifa_ctrl #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [lifa_pkg::LINK_W-1:0] csr_wdata,
   input  logic                       accept,
   input  logic                       operation,
   input  logic [lifa_pkg::BLK_W-1:0] block_in,
   input  logic [lifa_pkg::LINK_W-1:0] mem_rdata,
   output lifa_pkg::mem_req_type      mem_req,
   output lifa_pkg::result_type       result,
   output logic                       busy
);

   import lifa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;
   localparam int   TOTAL_RST_I = (TOTAL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : TOTAL_RESET;

   logic              state_ff, state_in;
   logic [LINK_W-1:0] total_ff, total_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] free_ff, free_in;
   logic [LINK_W-1:0] init_ff, init_in;
   logic              fwd_ff, fwd_in;
   logic [LINK_W-1:0] fwd_data_ff, fwd_data_in;
   logic              oob_ff, oob_in;
   logic [LINK_W-1:0] csr_clamped;
   logic [LINK_W-1:0] blk_ext;
   logic [LINK_W-1:0] link_val;
   logic              lazy_we;

   always_comb begin
      if (csr_wdata == '0) begin
         csr_clamped = LINK_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_BLOCKS)) begin
         csr_clamped = LINK_W'(MAX_BLOCKS);
      end else begin
         csr_clamped = csr_wdata;
      end
   end

   assign blk_ext  = LINK_W'(block_in);
   assign lazy_we  = (init_ff < total_ff) && (32'(init_ff) < 32'(MAX_BLOCKS));
   assign link_val = oob_ff ? '0 : (fwd_ff ? fwd_data_ff : mem_rdata);
   assign busy     = (state_ff == ST_POP);

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      init_in     = init_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      oob_in      = oob_ff;
      mem_req     = '{we: 1'b0, waddr: head_ff, wdata: '0, raddr: head_ff};
      result      = '{block_out: '0, granted: 1'b0, rejected: 1'b0, free_blocks: free_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (operation == OP_ALLOC) begin
                  // lazy link of the next untouched block
                  mem_req.we    = lazy_we;
                  mem_req.waddr = init_ff;
                  mem_req.wdata = init_ff + LINK_W'(1);
                  mem_req.raddr = head_ff;
                  if (lazy_we) begin
                     init_in = init_ff + LINK_W'(1);
                  end
                  fwd_in      = lazy_we && (init_ff == head_ff);
                  fwd_data_in = init_ff + LINK_W'(1);
                  oob_in      = (32'(head_ff) >= 32'(MAX_BLOCKS));
                  if (free_ff != '0) begin
                     free_in            = free_ff - LINK_W'(1);
                     result.block_out   = head_ff[BLK_W-1:0];
                     result.granted     = 1'b1;
                     result.free_blocks = free_ff - LINK_W'(1);
                     if (free_ff == LINK_W'(1)) begin
                        head_in = '0;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
               end else begin
                  if ((blk_ext >= total_ff) || (free_ff >= total_ff)) begin
                     result.rejected = 1'b1;
                  end else begin
                     mem_req.we         = 1'b1;
                     mem_req.waddr      = blk_ext;
                     mem_req.wdata      = (free_ff == '0) ? total_ff : head_ff;
                     head_in            = blk_ext;
                     free_in            = free_ff + LINK_W'(1);
                     result.granted     = 1'b1;
                     result.free_blocks = free_ff + LINK_W'(1);
                  end
               end
            end
         end
         ST_POP: begin
            head_in  = link_val;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // restart of the pool
      if (csr_we) begin
         total_in = csr_clamped;
         head_in  = '0;
         free_in  = csr_clamped;
         init_in  = '0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= LINK_W'(TOTAL_RST_I);
         head_ff  <= '0;
         free_ff  <= LINK_W'(TOTAL_RST_I);
         init_ff  <= '0;
         fwd_ff   <= 1'b0;
         oob_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         init_ff  <= init_in;
         fwd_ff   <= fwd_in;
         oob_ff   <= oob_in;
      end
      fwd_data_ff <= fwd_data_in;
   end

endmodule

>>> rtl/core/lazy_init_free_list_allocator.sv
// top level of the lazy-init free-list block allocator: ports, result register, link ram
// depends on lifa_pkg, lifa_ram, lifa_ctrl
//
//   channel | direction | tdata                                | tuser
//   req     | in        | block_in                             | operation
//   rsp     | out       | block_out, free_blocks               | granted, rejected
//   csr     | in        | total_blocks via csr_we / csr_wdata  | -
//
// a free, a refused allocate or one that takes the last free block has no pop state; any other
// allocate also enters the pop state, which waits on the registered link ram read of the head
// reset and a csr write restart the pool at once; links are set up lazily, no clearing pass
// a new item is taken only outside the pop cycle and while the result register is empty or
// being drained

module lazy_init_free_list_allocator #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lifa_pkg::REQ_DATA_W-1:0]   req_tdata,  // block_in, zero pad
   input  logic [lifa_pkg::REQ_USER_W-1:0]   req_tuser,  // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lifa_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // block_out, free_blocks, zero pad
   output logic [lifa_pkg::RSP_USER_W-1:0]   rsp_tuser,  // granted, rejected
   input  logic                              csr_we,
   input  logic [lifa_pkg::LINK_W-1:0]       csr_wdata
);

   import lifa_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);

   logic              accept;
   logic              busy;
   mem_req_type       mem_req;
   result_type        result;
   logic [LINK_W-1:0] mem_rdata;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   lifa_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .operation (req_tuser[0]),
      .block_in  (req_tdata[BLK_W-1:0]),
      .mem_rdata (mem_rdata),
      .mem_req   (mem_req),
      .result    (result),
      .busy      (busy)
   );

   lifa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (AW'(mem_req.waddr)),
      .wdata (mem_req.wdata),
      .raddr (AW'(mem_req.raddr)),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BLK_W - LINK_W){1'b0}}, rsp_ff.free_blocks,
                        rsp_ff.block_out};
   assign rsp_tuser  = {rsp_ff.rejected, rsp_ff.granted};

endmodule
